### sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock and active-low reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the house clock and reset names.
`define ASSERT_CR(lbl, prop, msg) `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

### sv/hrw_pkg.sv
package hrw_pkg;

  typedef enum logic [2:0] {
    CMD_SAMPLE     = 3'd0,
    CMD_CHECK      = 3'd1,
    CMD_WIN_START  = 3'd2,
    CMD_DEADLINE   = 3'd3,
    CMD_STOP_ALERT = 3'd4,
    CMD_DISARM     = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    PH_UNKNOWN = 2'd0,
    PH_LIGHT   = 2'd1,
    PH_DEEP    = 2'd2,
    PH_REM     = 2'd3
  } phase_e;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 5;

  localparam logic [CFG_IW-1:0] CFG_REQ_LIGHT   = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_DEEP_DROP   = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_LOW_SPREAD  = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_HIGH_SPREAD = 2'd3;

  localparam logic [3:0] STREAK_MAX = 4'd15;

  typedef struct packed {
    logic [3:0] req_light;
    logic [4:0] deep_drop;
    logic [3:0] low_spread;
    logic [4:0] high_spread;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    req_light:   4'd3,
    deep_drop:   5'd6,
    low_spread:  4'd3,
    high_spread: 5'd7
  };

  // Classifier status back to the controller.
  typedef struct packed {
    logic   done;
    phase_e phase;
  } cls_stat_t;

  function automatic int max2(int a, int b);
    return (a > b) ? a : b;
  endfunction

endpackage

### sv/hrw_hist_ram.sv
module hrw_hist_ram #(
  parameter int DEPTH = 60,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### sv/hrw_classify.sv
module hrw_classify #(
  parameter int ANALYSIS_DEPTH = 10,
  parameter int BASELINE_DEPTH = 60,
  parameter int MIN_SAMPLES    = 5
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         start_i,
  input  hrw_pkg::cfg_t                                cfg_i,
  input  logic [$clog2(BASELINE_DEPTH+1)-1:0]          count_i,
  input  logic [$clog2(((ANALYSIS_DEPTH < BASELINE_DEPTH) ? ANALYSIS_DEPTH
                        : BASELINE_DEPTH)*255+1)-1:0]   rsum_i,
  input  logic [$clog2(((ANALYSIS_DEPTH < BASELINE_DEPTH) ? ANALYSIS_DEPTH
                        : BASELINE_DEPTH)*65025+1)-1:0] rsq_i,
  input  logic [$clog2(BASELINE_DEPTH*255+1)-1:0]      bsum_i,
  output hrw_pkg::cls_stat_t                           stat_o
);

  localparam int RECENT_LEN = (ANALYSIS_DEPTH < BASELINE_DEPTH) ? ANALYSIS_DEPTH
                                                                : BASELINE_DEPTH;
  localparam int NW  = $clog2(RECENT_LEN+1);
  localparam int CW  = $clog2(BASELINE_DEPTH+1);
  localparam int QW  = $clog2(RECENT_LEN*65025+1);
  localparam int BSW = $clog2(BASELINE_DEPTH*255+1);
  localparam int OW  = hrw_pkg::max2(hrw_pkg::max2(QW, BSW),
                                     hrw_pkg::max2(NW+CW, hrw_pkg::max2(2*NW, 10)));
  localparam int PW  = 2*OW;

  typedef enum logic [3:0] {
    ST_NQ, ST_SS, ST_NN, ST_LT2, ST_LO, ST_HT2, ST_HI,
    ST_SM, ST_NM, ST_DNM, ST_BN, ST_DIFF, ST_DECIDE
  } step_e;

  step_e              step_q;
  logic               busy_q;
  hrw_pkg::cls_stat_t stat_q;

  logic [NW-1:0] n;
  logic [OW-1:0] op_a, op_b;
  logic [PW-1:0] prod;
  logic [PW-1:0] nq_q, ss_q, nn_q, lt2_q, lo_q, ht2_q, hi_q;
  logic [PW-1:0] sm_q, nm_q, dnm_q, bn_q, spread_q, lhs_q;
  logic          mean_low;
  hrw_pkg::phase_e phase_dec;

  // Samples in the recent window.
  assign n = (int'(count_i) < RECENT_LEN) ? NW'(count_i) : NW'(RECENT_LEN);

  // One shared multiplier, operands picked by step.
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (step_q)
      ST_NQ:   begin op_a = OW'(n);                   op_b = OW'(rsq_i);   end
      ST_SS:   begin op_a = OW'(rsum_i);              op_b = OW'(rsum_i);  end
      ST_NN:   begin op_a = OW'(n);                   op_b = OW'(n);       end
      ST_LT2:  begin op_a = OW'(cfg_i.low_spread);    op_b = OW'(cfg_i.low_spread); end
      ST_LO:   begin op_a = OW'(lt2_q);               op_b = OW'(nn_q);    end
      ST_HT2:  begin op_a = OW'(cfg_i.high_spread);   op_b = OW'(cfg_i.high_spread); end
      ST_HI:   begin op_a = OW'(ht2_q);               op_b = OW'(nn_q);    end
      ST_SM:   begin op_a = OW'(rsum_i);              op_b = OW'(count_i); end
      ST_NM:   begin op_a = OW'(n);                   op_b = OW'(count_i); end
      ST_DNM:  begin op_a = OW'(cfg_i.deep_drop);     op_b = OW'(nm_q);    end
      ST_BN:   begin op_a = OW'(bsum_i);              op_b = OW'(n);       end
      default: begin op_a = '0;                       op_b = '0;           end
    endcase
  end

  assign prod = op_a * op_b;

  // Recent mean below baseline by the drop, only once the baseline is longer.
  assign mean_low = (int'(count_i) > ANALYSIS_DEPTH) && (lhs_q < bn_q);

  always_comb begin
    if (mean_low && (spread_q < lo_q)) begin
      phase_dec = hrw_pkg::PH_DEEP;
    end else if (spread_q > hi_q) begin
      phase_dec = hrw_pkg::PH_REM;
    end else begin
      phase_dec = hrw_pkg::PH_LIGHT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      step_q       <= ST_NQ;
      stat_q.done  <= 1'b0;
      stat_q.phase <= hrw_pkg::PH_UNKNOWN;
    end else begin
      stat_q.done <= 1'b0;
      if (start_i) begin
        if (int'(n) < MIN_SAMPLES) begin
          stat_q.done  <= 1'b1;
          stat_q.phase <= hrw_pkg::PH_UNKNOWN;
        end else begin
          busy_q <= 1'b1;
          step_q <= ST_NQ;
        end
      end else if (busy_q) begin
        if (step_q == ST_DECIDE) begin
          busy_q       <= 1'b0;
          step_q       <= ST_NQ;
          stat_q.done  <= 1'b1;
          stat_q.phase <= phase_dec;
        end else begin
          step_q <= step_e'(step_q + 4'd1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      unique case (step_q)
        ST_NQ:   nq_q  <= prod;
        ST_SS:   ss_q  <= prod;
        ST_NN:   nn_q  <= prod;
        ST_LT2:  lt2_q <= prod;
        ST_LO:   lo_q  <= prod;
        ST_HT2:  ht2_q <= prod;
        ST_HI:   hi_q  <= prod;
        ST_SM:   sm_q  <= prod;
        ST_NM:   nm_q  <= prod;
        ST_DNM:  dnm_q <= prod;
        ST_BN:   bn_q  <= prod;
        ST_DIFF: begin
          spread_q <= nq_q - ss_q;
          lhs_q    <= sm_q + dnm_q;
        end
        default: ;
      endcase
    end
  end

  assign stat_o = stat_q;

endmodule

### sv/hr_sleep_phase_wake_detector.sv
// Sleep-phase wake detector. Each input word carries a command and a heart-rate
// sample; each accepted word returns exactly one result word with the wake pulse,
// the current phase, the window and alert flags and the light streak. Samples are
// kept in a synchronous ring memory of BASELINE_DEPTH entries; running sums over the
// recent ANALYSIS_DEPTH samples (at most BASELINE_DEPTH) and over the whole ring are
// updated as each sample goes in. A phase check in an open window, while not
// alerting, classifies the phase (unknown, light, deep, REM) by exact integer spread
// and mean tests. Light after deep or REM, or req_light light checks in a row,
// raises wake and starts alerting. Words are taken one at a time; a result may wait
// in the output register while the next word is accepted. A sample takes two memory
// reads of the retiring entries, two squarings and a write-back before its result;
// a full check runs the classifier's sequence of eleven products on one shared
// multiplier plus a subtract and a compare step, then the capture of the phase and
// the result. Configuration writes are taken in any cycle.
module hr_sleep_phase_wake_detector #(
  parameter int ANALYSIS_DEPTH = 10,
  parameter int BASELINE_DEPTH = 60,
  parameter int MIN_SAMPLES    = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [hrw_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [hrw_pkg::CFG_DW-1:0] cfg_data_i,
  // input words
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [2:0]                 command_i,
  input  logic [7:0]                 bpm_i,
  // result words
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       wake_o,
  output logic [1:0]                 phase_o,
  output logic                       in_window_o,
  output logic                       alerting_o,
  output logic [3:0]                 light_streak_o
);

  localparam int RECENT_LEN = (ANALYSIS_DEPTH < BASELINE_DEPTH) ? ANALYSIS_DEPTH
                                                                : BASELINE_DEPTH;
  localparam int AW  = $clog2(BASELINE_DEPTH);
  localparam int CW  = $clog2(BASELINE_DEPTH+1);
  localparam int RSW = $clog2(RECENT_LEN*255+1);
  localparam int QW  = $clog2(RECENT_LEN*65025+1);
  localparam int BSW = $clog2(BASELINE_DEPTH*255+1);

  typedef enum logic [2:0] {
    S_IDLE, S_RD_BASE, S_SQ, S_PUSH, S_CLS, S_RESP
  } state_e;

  state_e             state_q;
  hrw_pkg::cfg_t      cfg_q;
  hrw_pkg::cls_stat_t cls_stat;
  hrw_pkg::cmd_e      cmd;
  hrw_pkg::phase_e    phase_q;

  logic [CW-1:0]  count_q;
  logic [AW-1:0]  wp_q;
  logic [RSW-1:0] rsum_q;
  logic [QW-1:0]  rsq_q;
  logic [BSW-1:0] bsum_q;
  logic           win_q, alert_q, wake_q;
  logic [3:0]     streak_q, streak_inc;

  logic [7:0]     bpm_q, old_q, base_q;
  logic [15:0]    bsq_q, osq_q;

  logic           accept, check_ok, cls_start;
  logic           recent_full, base_full;
  logic           rd_en, wr_en;
  logic [AW-1:0]  rd_addr, old_addr;
  logic [7:0]     rd_data;

  logic           out_valid_q, out_wake_q, out_win_q, out_alert_q;
  logic [1:0]     out_phase_q;
  logic [3:0]     out_streak_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign cmd        = hrw_pkg::cmd_e'(command_i);

  // A check only counts inside an open window and while not alerting.
  assign check_ok   = win_q && !alert_q;
  assign cls_start  = accept && (cmd == hrw_pkg::CMD_CHECK) && check_ok;

  assign recent_full = int'(count_q) >= RECENT_LEN;
  assign base_full   = int'(count_q) >= BASELINE_DEPTH;

  assign streak_inc = (streak_q < hrw_pkg::STREAK_MAX) ? streak_q + 4'd1
                                                       : hrw_pkg::STREAK_MAX;

  // Entry leaving the recent window: RECENT_LEN behind the write pointer.
  always_comb begin
    if (int'(wp_q) >= RECENT_LEN) begin
      old_addr = AW'(int'(wp_q) - RECENT_LEN);
    end else begin
      old_addr = AW'(int'(wp_q) + BASELINE_DEPTH - RECENT_LEN);
    end
  end

  // Read the recent-window leaver on accept, then the baseline leaver at the
  // write pointer; write the new sample back once both are in hand.
  assign rd_en   = (accept && (cmd == hrw_pkg::CMD_SAMPLE)) || (state_q == S_RD_BASE);
  assign rd_addr = (state_q == S_IDLE) ? old_addr : wp_q;
  assign wr_en   = (state_q == S_PUSH);

  hrw_hist_ram #(
    .DEPTH (BASELINE_DEPTH),
    .WIDTH (8)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wp_q),
    .wdata_i (bpm_q),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  hrw_classify #(
    .ANALYSIS_DEPTH (ANALYSIS_DEPTH),
    .BASELINE_DEPTH (BASELINE_DEPTH),
    .MIN_SAMPLES    (MIN_SAMPLES)
  ) u_cls (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cls_start),
    .cfg_i   (cfg_q),
    .count_i (count_q),
    .rsum_i  (rsum_q),
    .rsq_i   (rsq_q),
    .bsum_i  (bsum_q),
    .stat_o  (cls_stat)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= hrw_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hrw_pkg::CFG_REQ_LIGHT:   cfg_q.req_light   <= cfg_data_i[3:0];
        hrw_pkg::CFG_DEEP_DROP:   cfg_q.deep_drop   <= cfg_data_i[4:0];
        hrw_pkg::CFG_LOW_SPREAD:  cfg_q.low_spread  <= cfg_data_i[3:0];
        hrw_pkg::CFG_HIGH_SPREAD: cfg_q.high_spread <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Sample path operands.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      bpm_q <= bpm_i;
    end
    if (state_q == S_RD_BASE) begin
      old_q <= rd_data;
      bsq_q <= 16'(bpm_q) * 16'(bpm_q);
    end
    if (state_q == S_SQ) begin
      base_q <= rd_data;
      osq_q  <= 16'(old_q) * 16'(old_q);
    end
  end

  // Controller, block state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      wp_q         <= '0;
      rsum_q       <= '0;
      rsq_q        <= '0;
      bsum_q       <= '0;
      win_q        <= 1'b0;
      alert_q      <= 1'b0;
      wake_q       <= 1'b0;
      phase_q      <= hrw_pkg::PH_UNKNOWN;
      streak_q     <= '0;
      out_valid_q  <= 1'b0;
      out_wake_q   <= 1'b0;
      out_phase_q  <= '0;
      out_win_q    <= 1'b0;
      out_alert_q  <= 1'b0;
      out_streak_q <= '0;
    end else begin
      // Drop the result word once taken, unless a new one is loaded behind it.
      if (out_valid_q && out_ready_i && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            wake_q <= 1'b0;
            unique case (cmd)
              hrw_pkg::CMD_SAMPLE: begin
                state_q <= S_RD_BASE;
              end
              hrw_pkg::CMD_CHECK: begin
                state_q <= check_ok ? S_CLS : S_RESP;
              end
              hrw_pkg::CMD_WIN_START: begin
                win_q    <= 1'b1;
                phase_q  <= hrw_pkg::PH_UNKNOWN;
                streak_q <= '0;
                state_q  <= S_RESP;
              end
              hrw_pkg::CMD_DEADLINE: begin
                win_q <= 1'b0;
                if (!alert_q) begin
                  alert_q <= 1'b1;
                  wake_q  <= 1'b1;
                end
                state_q <= S_RESP;
              end
              hrw_pkg::CMD_STOP_ALERT: begin
                alert_q  <= 1'b0;
                win_q    <= 1'b0;
                phase_q  <= hrw_pkg::PH_UNKNOWN;
                streak_q <= '0;
                state_q  <= S_RESP;
              end
              hrw_pkg::CMD_DISARM: begin
                win_q    <= 1'b0;
                phase_q  <= hrw_pkg::PH_UNKNOWN;
                streak_q <= '0;
                state_q  <= S_RESP;
              end
              default: begin
                state_q <= S_RESP;
              end
            endcase
          end
        end
        S_RD_BASE: begin
          state_q <= S_SQ;
        end
        S_SQ: begin
          state_q <= S_PUSH;
        end
        S_PUSH: begin
          // Add the new sample, retire the leavers once their windows are full.
          rsum_q <= rsum_q + RSW'(bpm_q) - (recent_full ? RSW'(old_q) : RSW'(0));
          rsq_q  <= rsq_q + QW'(bsq_q) - (recent_full ? QW'(osq_q) : QW'(0));
          bsum_q <= bsum_q + BSW'(bpm_q) - (base_full ? BSW'(base_q) : BSW'(0));
          if (!base_full) begin
            count_q <= count_q + CW'(1);
          end
          wp_q    <= (wp_q == AW'(BASELINE_DEPTH-1)) ? '0 : wp_q + AW'(1);
          state_q <= S_RESP;
        end
        S_CLS: begin
          if (cls_stat.done) begin
            phase_q <= cls_stat.phase;
            if (cls_stat.phase == hrw_pkg::PH_LIGHT) begin
              streak_q <= streak_inc;
              // Light straight after deep or REM, or a long enough run, wakes.
              if ((phase_q == hrw_pkg::PH_DEEP) || (phase_q == hrw_pkg::PH_REM) ||
                  (streak_inc >= cfg_q.req_light)) begin
                win_q   <= 1'b0;
                alert_q <= 1'b1;
                wake_q  <= 1'b1;
              end
            end else begin
              streak_q <= '0;
            end
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          // Hold until the output register is free.
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_wake_q   <= wake_q;
            out_phase_q  <= phase_q;
            out_win_q    <= win_q;
            out_alert_q  <= alert_q;
            out_streak_q <= streak_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign wake_o         = out_wake_q;
  assign phase_o        = out_phase_q;
  assign in_window_o    = out_win_q;
  assign alerting_o     = out_alert_q;
  assign light_streak_o = out_streak_q;

endmodule

### sv/hrw_checker.sv
`include "assert_macros.svh"

module hrw_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       wake_o,
  input logic [1:0] phase_o,
  input logic       in_window_o,
  input logic       alerting_o,
  input logic [3:0] light_streak_o
);

  // A wake pulse always closes the window and starts alerting.
  `ASSERT_CR(a_wake_alerts, out_valid_o && wake_o |-> alerting_o && !in_window_o, "wake without alert")

  // A running light streak is only reported with a light phase.
  `ASSERT_CR(a_streak_light, out_valid_o && (light_streak_o != 4'd0) |-> (phase_o == hrw_pkg::PH_LIGHT), "streak outside light")

  // Words are worked one at a time.
  `ASSERT_CR(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o, "ready straight after accept")

  // A stalled result word holds.
  `ASSERT_CR(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(wake_o) && $stable(phase_o) && $stable(light_streak_o), "stalled result changed")

endmodule

bind hr_sleep_phase_wake_detector hrw_checker u_hrw_checker (.*);

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  // Block sizing, kept equal to the instance parameters below.
  localparam int ANALYSIS_LEN = 10;
  localparam int RING_LEN     = 60;
  localparam int MIN_FOR_PHASE = 5;
  localparam int RECENT_LEN   = (ANALYSIS_LEN < RING_LEN) ? ANALYSIS_LEN : RING_LEN;

  // Codes the block must ignore.
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  // Cycles with no word moving on either side before the run is abandoned.
  // The slowest correct word is a full check behind a long sender gap and a long
  // receiver stall, and the limit is many times as long as that.
  localparam int WATCHDOG_LIMIT = 3000;
  // Quiet cycles before a register write and after the last result.
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct packed {
    logic            wake;
    hrw_pkg::phase_e phase;
    logic            in_window;
    logic            alerting;
    logic [3:0]      streak;
  } wake_status_t;

  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         cfg_we_i       = 1'b0;
  logic [hrw_pkg::CFG_IW-1:0]   cfg_idx_i      = '0;
  logic [hrw_pkg::CFG_DW-1:0]   cfg_data_i     = '0;
  logic                         in_valid_i     = 1'b0;
  logic                         in_ready_o;
  logic [2:0]                   command_i      = hrw_pkg::CMD_SAMPLE;
  logic [7:0]                   bpm_i          = '0;
  logic                         out_valid_o;
  logic                         out_ready_i    = 1'b0;
  logic                         wake_o;
  logic [1:0]                   phase_o;
  logic                         in_window_o;
  logic                         alerting_o;
  logic [3:0]                   light_streak_o;

  hr_sleep_phase_wake_detector #(
    .ANALYSIS_DEPTH (ANALYSIS_LEN),
    .BASELINE_DEPTH (RING_LEN),
    .MIN_SAMPLES    (MIN_FOR_PHASE)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .bpm_i          (bpm_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .wake_o         (wake_o),
    .phase_o        (phase_o),
    .in_window_o    (in_window_o),
    .alerting_o     (alerting_o),
    .light_streak_o (light_streak_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the detector: sample ring, running sums, flags and registers.
  // ---------------------------------------------------------------------------
  logic [7:0]      hr_ring [RING_LEN];
  int unsigned     n_stored;
  int unsigned     wr_ptr;
  int unsigned     sum_recent;
  int unsigned     sumsq_recent;
  int unsigned     sum_all;
  bit              win_open;
  bit              alert_on;
  hrw_pkg::phase_e cur_phase;
  hrw_pkg::phase_e last_phase;
  logic [3:0]      streak;
  hrw_pkg::cfg_t   cfg_now;

  wake_status_t status_due_q[$];
  int           words_sent;
  int           err_count    = 0;
  bit           word_held;
  bit           no_idle;
  int           ready_stall  = 0;
  int           quiet_cycles = 0;

  function automatic void reset_shadow();
    n_stored     = 0;
    wr_ptr       = 0;
    sum_recent   = 0;
    sumsq_recent = 0;
    sum_all      = 0;
    win_open     = 1'b0;
    alert_on     = 1'b0;
    cur_phase    = hrw_pkg::PH_UNKNOWN;
    last_phase   = hrw_pkg::PH_UNKNOWN;
    streak       = '0;
    cfg_now      = hrw_pkg::CFG_RESET;
  endfunction

  function automatic void forget_phases();
    cur_phase  = hrw_pkg::PH_UNKNOWN;
    last_phase = hrw_pkg::PH_UNKNOWN;
    streak     = '0;
  endfunction

  // Drop the sample leaving the recent window and, once the ring is full,
  // the one being overwritten; then add the new sample to every sum.
  function automatic void push_heart_rate(int unsigned bpm);
    int unsigned slot;
    int unsigned aged;
    slot = wr_ptr % RING_LEN;
    if (n_stored >= RECENT_LEN) begin
      aged = hr_ring[(slot + RING_LEN - RECENT_LEN) % RING_LEN];
      sum_recent   -= aged;
      sumsq_recent -= aged * aged;
    end
    if (n_stored >= RING_LEN) begin
      sum_all -= hr_ring[slot];
    end else begin
      n_stored++;
    end
    hr_ring[slot] = bpm[7:0];
    sum_recent   += bpm;
    sumsq_recent += bpm * bpm;
    sum_all      += bpm;
    wr_ptr = (slot + 1) % RING_LEN;
  endfunction

  // Spread tests without a square root: n*Q - S*S against t*t*n*n.
  // The mean test compares S/n + drop with B/m in cross-multiplied form.
  function automatic hrw_pkg::phase_e phase_from_stats();
    longint unsigned n, s, m, sprd, nn, lo_lim, hi_lim, lhs, rhs;
    bit mean_low;
    mean_low = 1'b0;
    n = (n_stored < RECENT_LEN) ? n_stored : RECENT_LEN;
    if (n < MIN_FOR_PHASE || n == 0) return hrw_pkg::PH_UNKNOWN;
    s      = sum_recent;
    sprd   = n * longint'(sumsq_recent) - s * s;
    nn     = n * n;
    lo_lim = longint'(cfg_now.low_spread) * longint'(cfg_now.low_spread) * nn;
    hi_lim = longint'(cfg_now.high_spread) * longint'(cfg_now.high_spread) * nn;
    if (n_stored > ANALYSIS_LEN) begin
      m   = n_stored;
      lhs = s * m + longint'(cfg_now.deep_drop) * n * m;
      rhs = longint'(sum_all) * n;
      mean_low = (lhs < rhs);
    end
    if (mean_low && sprd < lo_lim) return hrw_pkg::PH_DEEP;
    if (sprd > hi_lim) return hrw_pkg::PH_REM;
    return hrw_pkg::PH_LIGHT;
  endfunction

  // Advance the shadow by one word and return the status it should report.
  function automatic wake_status_t predict_status(logic [2:0] cmd, logic [7:0] bpm);
    wake_status_t st;
    logic wake;
    wake = 1'b0;
    case (cmd)
      hrw_pkg::CMD_SAMPLE: push_heart_rate(bpm);
      hrw_pkg::CMD_CHECK: begin
        if (!alert_on && win_open) begin
          last_phase = cur_phase;
          cur_phase  = phase_from_stats();
          if (cur_phase == hrw_pkg::PH_LIGHT) begin
            if (streak < hrw_pkg::STREAK_MAX) streak++;
            if (last_phase == hrw_pkg::PH_DEEP || last_phase == hrw_pkg::PH_REM ||
                streak >= cfg_now.req_light) begin
              win_open = 1'b0;
              alert_on = 1'b1;
              wake     = 1'b1;
            end
          end else begin
            streak = '0;
          end
        end
      end
      hrw_pkg::CMD_WIN_START: begin
        win_open = 1'b1;
        forget_phases();
      end
      hrw_pkg::CMD_DEADLINE: begin
        win_open = 1'b0;
        if (!alert_on) begin
          alert_on = 1'b1;
          wake     = 1'b1;
        end
      end
      hrw_pkg::CMD_STOP_ALERT: begin
        alert_on = 1'b0;
        win_open = 1'b0;
        forget_phases();
      end
      hrw_pkg::CMD_DISARM: begin
        win_open = 1'b0;
        forget_phases();
      end
      default: ;
    endcase
    st.wake      = wake;
    st.phase     = cur_phase;
    st.in_window = win_open;
    st.alerting  = alert_on;
    st.streak    = streak;
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // Idling: mostly back-to-back or short gaps, now and then a long one.
  // ---------------------------------------------------------------------------
  function automatic int idle_length();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int sender_gap();
    if (no_idle || $urandom_range(0, 99) < 55) return 0;
    return idle_length();
  endfunction

  // Receiver: hold ready low for random stretches; no new stretch starts while no_idle is set.
  always @(posedge clk_i) begin
    if (ready_stall > 0) begin
      ready_stall <= ready_stall - 1;
      out_ready_i <= 1'b0;
    end else if (no_idle || $urandom_range(0, 99) < 70) begin
      out_ready_i <= 1'b1;
    end else begin
      ready_stall <= idle_length() - 1;
      out_ready_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    err_count++;
    if (err_count <= 40)
      $display("%0t: %s mismatch: got %0d, want %0d", $realtime, what, got, want);
  endtask

  // Compare every result word with the oldest outstanding status.
  always @(posedge clk_i) begin
    wake_status_t due;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_due_q.size() == 0) begin
        report_mismatch("unexpected result word, count", 1, 0);
      end else begin
        due = status_due_q.pop_front();
        if (wake_o !== due.wake)         report_mismatch("wake", wake_o, due.wake);
        if (phase_o !== due.phase)       report_mismatch("phase", phase_o, int'(due.phase));
        if (in_window_o !== due.in_window)
          report_mismatch("in_window", in_window_o, due.in_window);
        if (alerting_o !== due.alerting) report_mismatch("alerting", alerting_o, due.alerting);
        if (light_streak_o !== due.streak)
          report_mismatch("light_streak", light_streak_o, due.streak);
      end
    end
  end

  // Abandon the run if nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  // Present one word and hold it until taken. Valid stays high afterwards so
  // the next word can follow at once; drop it first if a gap is wanted.
  task automatic send_word(logic [2:0] cmd, logic [7:0] bpm);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      if (word_held) in_valid_i <= 1'b0;
      word_held = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    bpm_i      <= bpm;
    word_held   = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    status_due_q.push_back(predict_status(cmd, bpm));
    words_sent++;
  endtask

  // Drop valid in the step the last word was taken; time must advance next.
  task automatic release_input();
    if (word_held) in_valid_i <= 1'b0;
    word_held = 1'b0;
  endtask

  // Wait until the block has answered everything, then write all registers.
  task automatic apply_config(logic [3:0] req, logic [4:0] drop, logic [3:0] lo,
                              logic [4:0] hi);
    release_input();
    do @(posedge clk_i); while (status_due_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= hrw_pkg::CFG_REQ_LIGHT;
    cfg_data_i <= {1'b0, req};
    @(posedge clk_i);
    cfg_now.req_light = req;
    cfg_idx_i  <= hrw_pkg::CFG_DEEP_DROP;
    cfg_data_i <= drop;
    @(posedge clk_i);
    cfg_now.deep_drop = drop;
    cfg_idx_i  <= hrw_pkg::CFG_LOW_SPREAD;
    cfg_data_i <= {1'b0, lo};
    @(posedge clk_i);
    cfg_now.low_spread = lo;
    cfg_idx_i  <= hrw_pkg::CFG_HIGH_SPREAD;
    cfg_data_i <= hi;
    @(posedge clk_i);
    cfg_now.high_spread = hi;
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] jitter_bpm(int level, int spread);
    int v;
    v = level + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    else if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Every command, the refused checks, too few samples, the extremes of bpm
  // and the codes that must be ignored.
  task automatic test_directed_commands();
    send_word(hrw_pkg::CMD_CHECK, 8'd0);          // window closed: refused
    send_word(CMD_SPARE_6, 8'd255);
    send_word(CMD_SPARE_7, 8'd170);
    send_word(hrw_pkg::CMD_WIN_START, 8'd85);
    send_word(hrw_pkg::CMD_CHECK, 8'd0);          // no samples yet: unknown
    send_word(hrw_pkg::CMD_SAMPLE, 8'd0);
    send_word(hrw_pkg::CMD_SAMPLE, 8'd255);
    send_word(hrw_pkg::CMD_SAMPLE, 8'd255);
    send_word(hrw_pkg::CMD_SAMPLE, 8'd0);
    send_word(hrw_pkg::CMD_CHECK, 8'd255);        // four samples: still unknown
    send_word(hrw_pkg::CMD_SAMPLE, 8'd128);
    send_word(hrw_pkg::CMD_CHECK, 8'd0);          // wide spread
    send_word(hrw_pkg::CMD_DEADLINE, 8'd0);       // wake and alert
    send_word(hrw_pkg::CMD_DEADLINE, 8'd0);       // already alerting: no second pulse
    send_word(hrw_pkg::CMD_WIN_START, 8'd0);
    send_word(hrw_pkg::CMD_CHECK, 8'd0);          // alerting: refused
    send_word(hrw_pkg::CMD_DISARM, 8'd0);         // alert survives a disarm
    send_word(hrw_pkg::CMD_STOP_ALERT, 8'd0);
    send_word(hrw_pkg::CMD_WIN_START, 8'd0);
    send_word(hrw_pkg::CMD_CHECK, 8'd0);
    send_word(hrw_pkg::CMD_DISARM, 8'd255);
  endtask

  // One night: open the window, feed runs of samples shaped as deep, REM or
  // light sleep with a check after each run, then close down in some way.
  task automatic run_night();
    int base, level, spread, n_checks;
    base     = $urandom_range(45, 110);
    n_checks = $urandom_range(2, 6);
    send_word(hrw_pkg::CMD_WIN_START, 8'($urandom));
    repeat (n_checks) begin
      case ($urandom_range(0, 2))
        0: begin
          level  = base - int'(cfg_now.deep_drop) - int'($urandom_range(4, 14));
          spread = $urandom_range(0, 1);
        end
        1: begin
          level  = base;
          spread = $urandom_range(12, 40);
        end
        default: begin
          level  = base + int'($urandom_range(0, 4));
          spread = $urandom_range(1, 8);
        end
      endcase
      repeat ($urandom_range(3, 12))
        send_word(hrw_pkg::CMD_SAMPLE, jitter_bpm(level, spread));
      send_word(hrw_pkg::CMD_CHECK, 8'($urandom));
      // Repeat the check now and then to build up a light streak.
      if ($urandom_range(0, 3) == 0) send_word(hrw_pkg::CMD_CHECK, 8'($urandom));
    end
    case ($urandom_range(0, 2))
      0: send_word(hrw_pkg::CMD_STOP_ALERT, 8'($urandom));
      1: begin
        send_word(hrw_pkg::CMD_DEADLINE, 8'($urandom));
        send_word(hrw_pkg::CMD_STOP_ALERT, 8'($urandom));
      end
      default: begin
        send_word(hrw_pkg::CMD_DISARM, 8'($urandom));
        if ($urandom_range(0, 1) == 1) send_word(hrw_pkg::CMD_STOP_ALERT, 8'($urandom));
      end
    endcase
  endtask

  task automatic test_sleep_nights(int n_words);
    int stop_at;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) run_night();
  endtask

  // Any code in any order, full-range bpm: broken sequences and noise.
  task automatic test_command_noise(int n_words);
    logic [2:0] codes [7];
    codes = '{hrw_pkg::CMD_CHECK, hrw_pkg::CMD_WIN_START, hrw_pkg::CMD_DEADLINE,
              hrw_pkg::CMD_STOP_ALERT, hrw_pkg::CMD_DISARM, CMD_SPARE_6, CMD_SPARE_7};
    repeat (n_words) begin
      if ($urandom_range(0, 99) < 45) send_word(hrw_pkg::CMD_SAMPLE, 8'($urandom));
      else send_word(codes[$urandom_range(0, 6)], 8'($urandom));
    end
  endtask

  // Nights with no idling on either side.
  task automatic test_back_to_back(int n_words);
    no_idle = 1'b1;
    test_sleep_nights(n_words);
    no_idle = 1'b0;
  endtask

  initial begin
    reset_shadow();
    words_sent  = 0;
    word_held   = 1'b0;
    no_idle     = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_commands();
    test_sleep_nights(90);                           // reset values
    apply_config(4'd1, 5'd0, 4'd15, 5'd0);           // one light check, REM on any nonzero spread
    test_sleep_nights(90);
    apply_config(4'd15, 5'd31, 4'd0, 5'd31);         // deep impossible, long streak
    test_sleep_nights(90);
    apply_config(4'd0, 5'd4, 4'd4, 5'd10);           // any light check wakes
    test_sleep_nights(90);
    apply_config(4'($urandom_range(1, 15)), 5'($urandom_range(0, 31)),
                 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)));
    test_sleep_nights(90);
    test_command_noise(80);
    apply_config(4'd3, 5'd6, 4'd3, 5'd7);
    test_back_to_back(60);
    test_command_noise(40);

    release_input();
    do @(posedge clk_i); while (status_due_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
